### hdl/bnst_pkg.sv
`timescale 1ns / 1ps

package bnst_pkg;

    // Token kinds as carried on the result tuser
    localparam logic [2:0] KIND_NUMBER = 3'd0;
    localparam logic [2:0] KIND_SBYTE  = 3'd1;
    localparam logic [2:0] KIND_SEND   = 3'd2;
    localparam logic [2:0] KIND_OPEN   = 3'd3;
    localparam logic [2:0] KIND_CLOSE  = 3'd4;
    localparam logic [2:0] KIND_ERROR  = 3'd5;

    // Error codes
    localparam logic ERR_INVALID  = 1'b0;
    localparam logic ERR_CAPACITY = 1'b1;

    localparam logic [15:0] CAPACITY_RESET = 16'd4096;

    typedef enum logic [5:0] {
        MODE_IDLE = 6'b000001,
        MODE_SIGN = 6'b000010,
        MODE_INT  = 6'b000100,
        MODE_FRAC = 6'b001000,
        MODE_STR  = 6'b010000,
        MODE_ESC  = 6'b100000
    } lex_mode_t;

    // One result beat
    typedef struct packed {
        logic [2:0]  kind;
        logic        neg;
        logic [31:0] int_val;
        logic [31:0] frac_val;
        logic [7:0]  ch;
        logic        code;
        logic        last;
    } result_t;

    // Results produced by one accepted input beat
    typedef struct packed {
        logic [1:0] cnt;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage

### hdl/bnst_lexer.sv
`timescale 1ns / 1ps

module bnst_lexer (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_accept,
    input  logic [7:0]      in_byte,
    input  logic            in_eoi,
    input  logic            cfg_we,
    input  logic [15:0]     cfg_wdata,
    output bnst_pkg::push_t push
);
    import bnst_pkg::*;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_OPEN  = 8'h5B;
    localparam logic [7:0] CH_CLOSE = 8'h5D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLSH = 8'h5C;
    localparam logic [7:0] CH_N     = 8'h6E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PRLO  = 8'd32;
    localparam logic [7:0] CH_PRHI  = 8'd126;

    lex_mode_t   mode_reg, mode_next;
    logic        neg_reg, neg_next;
    logic [31:0] int_reg, int_next;
    logic [31:0] frac_reg, frac_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] cap_reg;

    // Accumulate one decimal digit, saturating at all ones
    function automatic logic [31:0] acc10(input logic [31:0] a, input logic [3:0] d);
        logic [35:0] v;
        v = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + {32'd0, d};
        return (|v[35:32]) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic result_t mk(input logic [2:0] kind, input logic neg,
                                   input logic [31:0] iv, input logic [31:0] fv,
                                   input logic [7:0] ch, input logic code);
        result_t r;
        r.kind     = kind;
        r.neg      = neg;
        r.int_val  = iv;
        r.frac_val = fv;
        r.ch       = ch;
        r.code     = code;
        r.last     = 1'b0;
        return r;
    endfunction

    logic        is_digit;
    logic [3:0]  digit;
    logic        is_print;
    logic        str_full;
    logic [7:0]  esc_ch;
    result_t     num_res;
    result_t     err_res;

    // Fresh-token handling of a byte from idle
    lex_mode_t   i_mode;
    logic        i_neg;
    logic [31:0] i_int;
    logic        i_emit;
    result_t     i_res;

    result_t     r0, r1;
    logic [1:0]  cnt;

    always_comb begin
        is_digit = in_byte inside {[CH_ZERO:CH_NINE]};
        digit    = 4'(in_byte - CH_ZERO);
        is_print = in_byte inside {[CH_PRLO:CH_PRHI]};
        str_full = ({1'b0, len_reg} + 17'd1) >= {1'b0, cap_reg};
        esc_ch   = (in_byte == CH_N) ? CH_LF : in_byte;
        num_res  = mk(KIND_NUMBER, neg_reg, int_reg, frac_reg, 8'd0, ERR_INVALID);
        err_res  = mk(KIND_ERROR, 1'b0, 32'd0, 32'd0, 8'd0, ERR_INVALID);
    end

    // Decode a byte as the start of a new token
    always_comb begin
        i_mode = MODE_IDLE;
        i_neg  = 1'b0;
        i_int  = 32'd0;
        i_emit = 1'b0;
        i_res  = err_res;
        if (in_byte inside {CH_SPACE, CH_TAB, CH_LF}) begin
            i_emit = 1'b0;
        end else if (in_byte == CH_OPEN) begin
            i_emit = 1'b1;
            i_res  = mk(KIND_OPEN, 1'b0, 32'd0, 32'd0, 8'd0, ERR_INVALID);
        end else if (in_byte == CH_CLOSE) begin
            i_emit = 1'b1;
            i_res  = mk(KIND_CLOSE, 1'b0, 32'd0, 32'd0, 8'd0, ERR_INVALID);
        end else if (is_digit) begin
            i_mode = MODE_INT;
            i_int  = {28'd0, digit};
        end else if (in_byte == CH_MINUS) begin
            i_mode = MODE_SIGN;
            i_neg  = 1'b1;
        end else if (in_byte == CH_QUOTE) begin
            i_mode = MODE_STR;
        end else begin
            i_emit = 1'b1;
        end
    end

    // Main step: next state and up to two results
    always_comb begin
        mode_next = mode_reg;
        neg_next  = neg_reg;
        int_next  = int_reg;
        frac_next = frac_reg;
        len_next  = len_reg;
        r0        = err_res;
        r1        = err_res;
        cnt       = 2'd0;

        if (in_eoi) begin
            if (mode_reg inside {MODE_SIGN, MODE_INT, MODE_FRAC}) begin
                r0  = num_res;
                cnt = 2'd1;
            end else if (mode_reg inside {MODE_STR, MODE_ESC}) begin
                cnt = 2'd1;
            end
            mode_next = MODE_IDLE;
            neg_next  = 1'b0;
            int_next  = 32'd0;
            frac_next = 32'd0;
            len_next  = 16'd0;
        end else begin
            case (mode_reg)
                MODE_SIGN, MODE_INT, MODE_FRAC: begin
                    if (is_digit && mode_reg == MODE_FRAC) begin
                        frac_next = acc10(frac_reg, digit);
                    end else if (is_digit) begin
                        int_next  = acc10(int_reg, digit);
                        mode_next = MODE_INT;
                    end else if (in_byte == CH_DOT && mode_reg != MODE_FRAC) begin
                        mode_next = MODE_FRAC;
                    end else begin
                        // Flush the number, then treat the byte as a new token
                        r0        = num_res;
                        r1        = i_res;
                        cnt       = i_emit ? 2'd2 : 2'd1;
                        mode_next = i_mode;
                        neg_next  = i_neg;
                        int_next  = i_int;
                        frac_next = 32'd0;
                        len_next  = 16'd0;
                    end
                end
                MODE_STR, MODE_ESC: begin
                    if (mode_reg == MODE_STR && in_byte == CH_BSLSH) begin
                        mode_next = MODE_ESC;
                    end else if (mode_reg == MODE_STR && in_byte == CH_QUOTE) begin
                        r0        = mk(KIND_SEND, 1'b0, 32'd0, 32'd0, 8'd0, ERR_INVALID);
                        cnt       = 2'd1;
                        mode_next = MODE_IDLE;
                        len_next  = 16'd0;
                    end else if ((mode_reg == MODE_STR && is_print) ||
                                 (mode_reg == MODE_ESC &&
                                  (in_byte inside {CH_BSLSH, CH_QUOTE, CH_N}))) begin
                        cnt = 2'd1;
                        if (str_full) begin
                            r0        = mk(KIND_ERROR, 1'b0, 32'd0, 32'd0, 8'd0,
                                           ERR_CAPACITY);
                            mode_next = MODE_IDLE;
                            len_next  = 16'd0;
                        end else begin
                            r0        = mk(KIND_SBYTE, 1'b0, 32'd0, 32'd0,
                                           (mode_reg == MODE_ESC) ? esc_ch : in_byte,
                                           ERR_INVALID);
                            mode_next = MODE_STR;
                            len_next  = len_reg + 16'd1;
                        end
                    end else begin
                        cnt       = 2'd1;
                        mode_next = MODE_IDLE;
                        len_next  = 16'd0;
                    end
                end
                default: begin
                    r0        = i_res;
                    cnt       = i_emit ? 2'd1 : 2'd0;
                    mode_next = i_mode;
                    neg_next  = i_neg;
                    int_next  = i_int;
                    frac_next = 32'd0;
                    len_next  = 16'd0;
                end
            endcase
        end

        // Mark the final result of this beat
        if (cnt == 2'd2) begin
            r1.last = 1'b1;
        end else begin
            r0.last = 1'b1;
        end
    end

    assign push.cnt = in_accept ? cnt : 2'd0;
    assign push.r0  = r0;
    assign push.r1  = r1;

    // Lexer state, updated on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            neg_reg  <= 1'b0;
            int_reg  <= 32'd0;
            frac_reg <= 32'd0;
            len_reg  <= 16'd0;
        end else if (in_accept) begin
            mode_reg <= mode_next;
            neg_reg  <= neg_next;
            int_reg  <= int_next;
            frac_reg <= frac_next;
            len_reg  <= len_next;
        end
    end

    // Capacity register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAPACITY_RESET;
        end else if (cfg_we) begin
            cap_reg <= cfg_wdata;
        end
    end

endmodule

### hdl/bnst_result_fifo.sv
`timescale 1ns / 1ps

// Result queue; DEPTH must be a power of two, at least 2
module bnst_result_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  bnst_pkg::push_t   push,
    output logic              room,
    output logic              out_valid,
    input  logic              out_ready,
    output bnst_pkg::result_t out_res
);
    import bnst_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    result_t         mem [DEPTH];
    logic [AW-1:0]   wr_reg, wr_next;
    logic [AW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    // Keep space for the two results one beat can cause
    assign room      = (count_reg <= CW'(DEPTH - 2));
    assign out_res   = mem[rd_reg];

    always_comb begin
        wr_next    = wr_reg + AW'(push.cnt);
        rd_next    = pop ? rd_reg + AW'(1) : rd_reg;
        count_next = count_reg + CW'(push.cnt) - CW'(pop);
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end else begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // Store pushed results
    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem[wr_reg] <= push.r0;
        end
        if (push.cnt == 2'd2) begin
            mem[wr_reg + AW'(1)] <= push.r1;
        end
    end

endmodule

### hdl/bracket_number_string_tokenizer_unit.sv
`timescale 1ns / 1ps
// Results: each result beat is written to the result queue and offered from its head.
// Input: one input beat per cycle while the result queue has room for two results;
// beats causing two results can fill the queue faster than it drains, which then holds the input.
// Reset: aresetn synchronous, active low; clears lexer state and queue, sets
// string capacity to 4096.

module bracket_number_string_tokenizer_unit #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] source_byte
    input  logic        s_tlast,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] negative_sign, [32:1] integer_value, [64:33] fraction_value,
    // [72:65] string_char, [73] error_code, [79:74] zero
    output logic [79:0] m_tdata,
    output logic [2:0]  m_tuser,   // [2:0] token_kind
    output logic        m_tlast,   // last_result
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import bnst_pkg::*;

    push_t   push;
    result_t head;
    logic    in_accept;

    assign in_accept = s_tvalid && s_tready;

    bnst_lexer u_lexer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_eoi    (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push)
    );

    bnst_result_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (head)
    );

    // Pack the head result onto the master beat
    assign m_tdata = {6'd0, head.code, head.ch, head.frac_val, head.int_val, head.neg};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

### hdl/bnst_checker.sv
`timescale 1ns / 1ps

module bnst_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);
    import bnst_pkg::*;

    // Hold a stalled result beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result beat changed");

    // An error always closes the results of its input beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_ERROR |-> m_tlast)
        else $error("error result not marked last");

    // A string end is the only result of its beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_SEND |-> m_tlast)
        else $error("string end not marked last");

    // Number fields are zero on every other kind
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_NUMBER |-> m_tdata[64:0] == 65'd0)
        else $error("number fields set on non-number result");

endmodule

bind bracket_number_string_tokenizer_unit bnst_checker u_bnst_checker (.*);

### verif/tokenizer_checker.sv
`timescale 1ns / 1ps

module tokenizer_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] source_byte
    input  logic        s_tlast,   // end_of_input
    input  logic        m_tvalid,
    input  logic        m_tready,
    // [0] negative_sign, [32:1] integer_value, [64:33] fraction_value,
    // [72:65] string_char, [73] error_code, [79:74] zero
    input  logic [79:0] m_tdata,
    input  logic [2:0]  m_tuser,   // [2:0] token_kind
    input  logic        m_tlast,   // last_result
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output int          failures,
    output int          tokens_checked,
    output int          tokens_pending
);

    import bnst_pkg::*;

    // Shadow lexer state
    lex_mode_t   mode;
    logic        neg_flag;
    logic [31:0] int_acc;
    logic [31:0] frac_acc;
    logic [15:0] str_len;
    logic [15:0] capacity;

    // Tokens predicted but not yet seen on the result channel
    result_t token_q[$];
    int      fail_cnt = 0;
    int      seen_cnt = 0;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    // Base-ten accumulate, clamped at all ones
    function automatic logic [31:0] mul10_add(input logic [31:0] acc, input logic [7:0] c);
        logic [35:0] sum;
        sum = 36'(acc) * 36'd10 + 36'(c) - 36'("0");
        return (sum > 36'hFFFF_FFFF) ? '1 : sum[31:0];
    endfunction

    task automatic push_token(input logic [2:0] kind, input logic neg, input logic [31:0] iv,
                              input logic [31:0] fv, input logic [7:0] ch, input logic code);
        result_t r;
        r.kind     = kind;
        r.neg      = neg;
        r.int_val  = iv;
        r.frac_val = fv;
        r.ch       = ch;
        r.code     = code;
        r.last     = 1'b0;
        token_q.push_back(r);
    endtask

    task automatic clear_lexer();
        mode     = MODE_IDLE;
        neg_flag = 1'b0;
        int_acc  = '0;
        frac_acc = '0;
        str_len  = '0;
    endtask

    task automatic flush_number();
        push_token(KIND_NUMBER, neg_flag, int_acc, frac_acc, 8'd0, 1'b0);
        clear_lexer();
    endtask

    // Handle a byte that begins a new token
    task automatic start_token(input logic [7:0] c);
        clear_lexer();
        if (c == " " || c == "\t" || c == "\n") begin
            return;
        end
        if (c == "[") begin
            push_token(KIND_OPEN, 1'b0, '0, '0, 8'd0, 1'b0);
        end else if (c == "]") begin
            push_token(KIND_CLOSE, 1'b0, '0, '0, 8'd0, 1'b0);
        end else if (is_digit(c)) begin
            mode    = MODE_INT;
            int_acc = 32'(c - "0");
        end else if (c == "-") begin
            mode     = MODE_SIGN;
            neg_flag = 1'b1;
        end else if (c == "\"") begin
            mode = MODE_STR;
        end else begin
            push_token(KIND_ERROR, 1'b0, '0, '0, 8'd0, ERR_INVALID);
        end
    endtask

    // Store one decoded string byte unless the capacity is reached
    task automatic add_string_byte(input logic [7:0] c);
        if (({1'b0, str_len} + 17'd1) >= {1'b0, capacity}) begin
            push_token(KIND_ERROR, 1'b0, '0, '0, 8'd0, ERR_CAPACITY);
            clear_lexer();
            return;
        end
        str_len = str_len + 16'd1;
        push_token(KIND_SBYTE, 1'b0, '0, '0, c, 1'b0);
        mode = MODE_STR;
    endtask

    task automatic error_to_idle();
        push_token(KIND_ERROR, 1'b0, '0, '0, 8'd0, ERR_INVALID);
        clear_lexer();
    endtask

    // Advance the shadow lexer by one source beat
    task automatic tokenize(input logic [7:0] c, input logic eoi);
        int      before_n;
        result_t tail;
        before_n = token_q.size();
        if (eoi) begin
            if (mode == MODE_SIGN || mode == MODE_INT || mode == MODE_FRAC) begin
                flush_number();
            end else if (mode == MODE_STR || mode == MODE_ESC) begin
                push_token(KIND_ERROR, 1'b0, '0, '0, 8'd0, ERR_INVALID);
            end
            clear_lexer();
        end else begin
            case (mode)
                MODE_SIGN, MODE_INT: begin
                    if (is_digit(c)) begin
                        int_acc = mul10_add(int_acc, c);
                        mode    = MODE_INT;
                    end else if (c == ".") begin
                        mode = MODE_FRAC;
                    end else begin
                        flush_number();
                        start_token(c);
                    end
                end
                MODE_FRAC: begin
                    if (is_digit(c)) begin
                        frac_acc = mul10_add(frac_acc, c);
                    end else begin
                        flush_number();
                        start_token(c);
                    end
                end
                MODE_STR: begin
                    if (c == "\\") begin
                        mode = MODE_ESC;
                    end else if (c == "\"") begin
                        push_token(KIND_SEND, 1'b0, '0, '0, 8'd0, 1'b0);
                        clear_lexer();
                    end else if (c >= " " && c <= "~") begin
                        add_string_byte(c);
                    end else begin
                        error_to_idle();
                    end
                end
                MODE_ESC: begin
                    if (c == "\\" || c == "\"") begin
                        add_string_byte(c);
                    end else if (c == "n") begin
                        add_string_byte("\n");
                    end else begin
                        error_to_idle();
                    end
                end
                default: begin
                    start_token(c);
                end
            endcase
        end
        // Mark the final token of this beat
        if (token_q.size() > before_n) begin
            tail      = token_q.pop_back();
            tail.last = 1'b1;
            token_q.push_back(tail);
        end
    endtask

    task automatic check_field(input string label, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want_v, got_v);
            fail_cnt++;
        end
    endtask

    // Predict on accepted input beats, compare on accepted result beats
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            capacity = CAPACITY_RESET;
            clear_lexer();
            token_q.delete();
        end else begin
            if (cfg_we) begin
                capacity = cfg_wdata;
            end
            if (s_tvalid && s_tready) begin
                tokenize(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready) begin
                if (token_q.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, actual kind %0d",
                             $time, m_tuser);
                    fail_cnt++;
                end else begin
                    want = token_q.pop_front();
                    check_field("token_kind", 32'(want.kind), 32'(m_tuser));
                    check_field("negative_sign", 32'(want.neg), 32'(m_tdata[0]));
                    check_field("integer_value", want.int_val, m_tdata[32:1]);
                    check_field("fraction_value", want.frac_val, m_tdata[64:33]);
                    check_field("string_char", 32'(want.ch), 32'(m_tdata[72:65]));
                    check_field("error_code", 32'(want.code), 32'(m_tdata[73]));
                    check_field("last_result", 32'(want.last), 32'(m_tlast));
                    seen_cnt++;
                end
            end
        end
        failures       <= fail_cnt;
        tokens_checked <= seen_cnt;
        tokens_pending <= token_q.size();
    end

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    import bnst_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] source_byte
    logic        s_tlast;   // end_of_input
    logic        m_tvalid;
    logic        m_tready;
    // [0] negative_sign, [32:1] integer_value, [64:33] fraction_value,
    // [72:65] string_char, [73] error_code, [79:74] zero
    logic [79:0] m_tdata;
    logic [2:0]  m_tuser;   // [2:0] token_kind
    logic        m_tlast;   // last_result
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    int failures;
    int tokens_checked;
    int tokens_pending;

    int beats_sent  = 0;
    int busy_beats  = 0;
    int cap_writes  = 0;
    bit tx_idle_on  = 1'b1;
    bit rx_stall_on = 1'b1;
    bit rx_hold_req = 1'b0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    bracket_number_string_tokenizer_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    tokenizer_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .failures       (failures),
        .tokens_checked (tokens_checked),
        .tokens_pending (tokens_pending)
    );

    // Offer one source beat after a random gap and hold it until accepted
    task automatic send_beat(input logic [7:0] c, input logic eoi);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eoi;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        beats_sent++;
        if (eoi || !(c == " " || c == "\t" || c == "\n")) begin
            busy_beats++;
        end
    endtask

    task automatic send_text(input string t);
        foreach (t[i]) send_beat(t[i], 1'b0);
    endtask

    task automatic send_eoi();
        send_beat(8'($urandom), 1'b1);
    endtask

    task automatic send_digits(input int count);
        repeat (count) send_beat("0" + 8'($urandom_range(0, 9)), 1'b0);
    endtask

    // Stop offering, then wait for every predicted token
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tokens_pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        cap_writes++;
    endtask

    // Optional sign, integer digits, optional fraction; long runs saturate
    task automatic send_number();
        bit minus;
        int pick;
        minus = ($urandom_range(0, 2) == 0);
        if (minus) send_beat("-", 1'b0);
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            send_text("4294967295");
        end else if (pick == 1) begin
            send_text("4294967296");
        end else begin
            send_digits($urandom_range(minus ? 0 : 1, (pick < 5) ? 14 : 4));
        end
        if ($urandom_range(0, 2) == 0) begin
            send_beat(".", 1'b0);
            send_digits($urandom_range(0, ($urandom_range(0, 4) == 0) ? 14 : 4));
            if ($urandom_range(0, 9) == 0) send_beat(".", 1'b0);
        end
    endtask

    // Quoted string with plain bytes and escapes; some are broken on purpose
    task automatic send_string();
        int         len;
        int         pick;
        logic [7:0] c;
        send_beat("\"", 1'b0);
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
        repeat (len) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                do c = 8'($urandom_range(" ", "~")); while (c == "\"" || c == "\\");
                send_beat(c, 1'b0);
            end else if (pick < 88) begin
                send_beat("\\", 1'b0);
                case ($urandom_range(0, 2))
                    0: send_beat("\\", 1'b0);
                    1: send_beat("\"", 1'b0);
                    default: send_beat("n", 1'b0);
                endcase
            end else if (pick < 93) begin
                send_beat("\\", 1'b0);
                do c = 8'($urandom); while (c == "\\" || c == "\"" || c == "n");
                send_beat(c, 1'b0);
                return;
            end else if (pick < 97) begin
                do c = 8'($urandom); while (c >= " " && c <= "~");
                send_beat(c, 1'b0);
                return;
            end else begin
                send_eoi();
                return;
            end
        end
        send_beat("\"", 1'b0);
    endtask

    // Mostly well-formed token streams, with noise and end-of-text marks
    task automatic random_text(input int count);
        int stop_at;
        int pick;
        stop_at = busy_beats + count;
        while (busy_beats < stop_at) begin
            if ($urandom_range(0, 39) == 0) tx_idle_on = !tx_idle_on;
            if ($urandom_range(0, 39) == 0) rx_stall_on = !rx_stall_on;
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_number();
                case ($urandom_range(0, 4))
                    0: send_beat(" ", 1'b0);
                    1: send_beat("\n", 1'b0);
                    2: send_beat("]", 1'b0);
                    3: send_eoi();
                    default: ;
                endcase
            end else if (pick < 55) begin
                send_string();
            end else if (pick < 75) begin
                send_beat(($urandom_range(0, 1) == 0) ? "[" : "]", 1'b0);
            end else if (pick < 85) begin
                case ($urandom_range(0, 2))
                    0: send_beat(" ", 1'b0);
                    1: send_beat("\t", 1'b0);
                    default: send_beat("\n", 1'b0);
                endcase
            end else if (pick < 90) begin
                send_eoi();
            end else begin
                send_beat(8'($urandom), 1'b0);
            end
        end
    endtask

    // Result side: random stalls per beat, one long hold-off on request
    initial begin
        int wait_cycles;
        bit hold_done;
        hold_done = 1'b0;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            wait_cycles = rx_stall_on ? $urandom_range(0, 16) : 0;
            if (rx_hold_req && !hold_done) begin
                hold_done   = 1'b1;
                wait_cycles = 300;
            end
            if (wait_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Stimulus and verdict
    initial begin
        logic [15:0] cap_plan[$];
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= 8'd0;
        s_tlast   <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_wdata <= 16'd0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: brackets, second point, lone minus, escapes, bad bytes
        send_text("[-9.5.-]");
        send_text("\"\\n\\\\\\\"");
        send_beat("\t", 1'b0);
        send_beat("a", 1'b0);
        send_beat(8'd0, 1'b0);
        send_beat(8'd255, 1'b0);
        send_text("\"\\q");
        send_beat("\"", 1'b0);
        send_eoi();
        send_eoi();
        send_text(" \n-.3");
        send_eoi();
        drain();

        // Random phases over a range of capacities, extremes included
        cap_plan = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd5, 16'd65535,
                     16'($urandom_range(4, 24)), CAPACITY_RESET,
                     16'($urandom_range(1, 65535))};
        foreach (cap_plan[i]) begin
            write_capacity(cap_plan[i]);
            random_text(175);
            drain();
        end

        // Back-pressure: hold the result side while a burst of brackets fills the block
        rx_hold_req = 1'b1;
        tx_idle_on  = 1'b0;
        repeat (30) send_beat(($urandom_range(0, 1) == 0) ? "[" : "]", 1'b0);
        drain();

        $display("Run covered %0d source beats across %0d capacity writes (zero, one, 65535).",
                 beats_sent, cap_writes);
        $display("Compared %0d result beats, including a long result-side hold-off.",
                 tokens_checked);
        if (failures == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #10_000_000;
        $display("Timeout with %0d result beats outstanding", tokens_pending);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
